// ===== hdl/fcc_pkg.sv =====
// Shared types, constants and helpers for the force contact classifier.
// Used by the configuration register file, the per-foot update logic and the top level.
package fcc_pkg;

    localparam int NUM_FEET   = 4;
    localparam int WINDOW_MAX = 16;

    localparam int FOOT_W      = 2;
    localparam int FORCE_W     = 32;
    localparam int LEVEL_W     = 31;
    localparam int DELTA_W     = 32;
    localparam int WIN_CFG_W   = 5;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int RUN_W       = $clog2(WINDOW_MAX + 1);
    localparam int FEET_IDX_W  = (NUM_FEET > 1) ? $clog2(NUM_FEET) : 1;
    localparam int FOOT_CMP_W  = FOOT_W + 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORCE_ON_LEVEL    = 3'd0,
        CFG_FORCE_OFF_LEVEL   = 3'd1,
        CFG_MAX_FORCE_DELTA   = 3'd2,
        CFG_WINDOW_LENGTH     = 3'd3,
        CFG_ON_SAMPLES        = 3'd4,
        CFG_DELTA_OFF_SAMPLES = 3'd5,
        CFG_USE_WINDOW        = 3'd6,
        CFG_USE_ABS_FORCE     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   force_on_level;
        logic [LEVEL_W-1:0]   force_off_level;
        logic [DELTA_W-1:0]   max_force_delta;
        logic [WIN_CFG_W-1:0] window_length;
        logic [COUNT_W-1:0]   on_samples;
        logic [COUNT_W-1:0]   delta_off_samples;
        logic                 use_window;
        logic                 use_abs_force;
    } cfg_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] last_force;
        logic                      have_last_force;
        logic [RUN_W-1:0]          stable_run;
        logic [RUN_W-1:0]          deltas_held;
        logic                      contact_active;
        logic [COUNT_W-1:0]        large_delta_count;
        logic [COUNT_W-1:0]        qualify_count;
    } foot_state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ===== hdl/fcc_cfg_regs.sv =====
// Configuration register file of the force contact classifier.
// Depends on fcc_pkg for the register index codes and the cfg_t layout.
module fcc_cfg_regs import fcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FORCE_ON_LEVEL:    cfg_next.force_on_level    = cfg_data[LEVEL_W-1:0];
                CFG_FORCE_OFF_LEVEL:   cfg_next.force_off_level   = cfg_data[LEVEL_W-1:0];
                CFG_MAX_FORCE_DELTA:   cfg_next.max_force_delta   = cfg_data[DELTA_W-1:0];
                CFG_WINDOW_LENGTH:     cfg_next.window_length     = cfg_data[WIN_CFG_W-1:0];
                CFG_ON_SAMPLES:        cfg_next.on_samples        = cfg_data[COUNT_W-1:0];
                CFG_DELTA_OFF_SAMPLES: cfg_next.delta_off_samples = cfg_data[COUNT_W-1:0];
                CFG_USE_WINDOW:        cfg_next.use_window        = cfg_data[0];
                CFG_USE_ABS_FORCE:     cfg_next.use_abs_force     = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_on_level    <= LEVEL_W'(51200);
            cfg_reg.force_off_level   <= LEVEL_W'(30720);
            cfg_reg.max_force_delta   <= DELTA_W'(10240);
            cfg_reg.window_length     <= WIN_CFG_W'(4);
            cfg_reg.on_samples        <= COUNT_W'(2);
            cfg_reg.delta_off_samples <= COUNT_W'(3);
            cfg_reg.use_window        <= 1'b1;
            cfg_reg.use_abs_force     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/fcc_eval.sv =====
// Single-sample update of one foot's contact state: force conditioning, delta
// check, window counters and the on/off decision. Depends on fcc_pkg.
module fcc_eval import fcc_pkg::*;
(
    input  cfg_t                      cfg,
    input  foot_state_t               cur,
    input  logic signed [FORCE_W-1:0] force_req,
    input  logic                      force_valid,
    output foot_state_t               nxt,
    output logic                      now_active,
    output logic                      touchdown
);

    logic signed [FORCE_W-1:0] force_val;
    logic signed [FORCE_W:0]   diff_pos;
    logic signed [FORCE_W:0]   diff_neg;
    logic [DELTA_W-1:0]        delta_abs;
    logic                      delta_ok;
    logic [RUN_W-1:0]          wlen;
    logic [RUN_W:0]            held_inc;
    logic [RUN_W-1:0]          run_n;
    logic [RUN_W-1:0]          held_n;
    logic                      stable;
    logic                      too_large;
    logic [COUNT_W-1:0]        ldc_n;
    logic [COUNT_W-1:0]        qual_n;
    logic                      active_n;
    logic signed [FORCE_W-1:0] off_level_s;
    logic signed [FORCE_W-1:0] on_level_s;

    // The most negative force has no positive twin and saturates instead.
    always_comb
    begin
        force_val = force_req;
        if (cfg.use_abs_force && force_req[FORCE_W-1])
        begin
            if (force_req == {1'b1, {(FORCE_W-1){1'b0}}})
                force_val = {1'b0, {(FORCE_W-1){1'b1}}};
            else
                force_val = -force_req;
        end
    end

    // Both differences are formed in parallel so the magnitude is a select.
    assign diff_pos  = {force_val[FORCE_W-1], force_val} -
                       {cur.last_force[FORCE_W-1], cur.last_force};
    assign diff_neg  = {cur.last_force[FORCE_W-1], cur.last_force} -
                       {force_val[FORCE_W-1], force_val};
    assign delta_abs = diff_pos[FORCE_W] ? diff_neg[DELTA_W-1:0] : diff_pos[DELTA_W-1:0];
    assign delta_ok  = delta_abs <= cfg.max_force_delta;

    always_comb
    begin
        if (cfg.window_length == '0)
            wlen = RUN_W'(1);
        else if (RUN_W'(cfg.window_length) > RUN_W'(WINDOW_MAX))
            wlen = RUN_W'(WINDOW_MAX);
        else
            wlen = RUN_W'(cfg.window_length);
    end

    assign held_inc    = {1'b0, cur.deltas_held} + (RUN_W+1)'(1);
    assign off_level_s = $signed({1'b0, cfg.force_off_level});
    assign on_level_s  = $signed({1'b0, cfg.force_on_level});

    always_comb
    begin
        run_n  = cur.stable_run;
        held_n = cur.deltas_held;
        if (cur.have_last_force)
        begin
            if (!delta_ok)
                run_n = '0;
            else if (cur.stable_run >= RUN_W'(WINDOW_MAX))
                run_n = RUN_W'(WINDOW_MAX);
            else
                run_n = cur.stable_run + RUN_W'(1);

            if (held_inc > {1'b0, wlen})
                held_n = wlen;
            else
                held_n = held_inc[RUN_W-1:0];
        end

        if (cfg.use_window)
            stable = (held_n == wlen) && (run_n >= held_n);
        else
            stable = cur.have_last_force && delta_ok;

        too_large = !cur.have_last_force || !delta_ok;
        ldc_n     = cur.large_delta_count;
        qual_n    = cur.qualify_count;

        if (cur.contact_active)
        begin
            ldc_n    = too_large ? sat_inc(cur.large_delta_count) : '0;
            active_n = (force_val > off_level_s) && (ldc_n < cfg.delta_off_samples);
            if (!active_n)
            begin
                qual_n = '0;
                ldc_n  = '0;
            end
        end
        else
        begin
            qual_n   = ((force_val >= on_level_s) && stable) ?
                       sat_inc(cur.qualify_count) : '0;
            active_n = qual_n >= cfg.on_samples;
            if (active_n)
            begin
                qual_n = '0;
                ldc_n  = '0;
            end
        end
    end

    // An invalid sample wipes the foot and reports no contact.
    always_comb
    begin
        if (force_valid)
        begin
            nxt.last_force        = force_val;
            nxt.have_last_force   = 1'b1;
            nxt.stable_run        = run_n;
            nxt.deltas_held       = held_n;
            nxt.contact_active    = active_n;
            nxt.large_delta_count = ldc_n;
            nxt.qualify_count     = qual_n;
            now_active            = active_n;
            touchdown             = active_n && !cur.contact_active;
        end
        else
        begin
            nxt        = '0;
            now_active = 1'b0;
            touchdown  = 1'b0;
        end
    end

endmodule

// ===== hdl/force_contact_classifier_unit.sv =====
// An accepted word is captured in the input register, evaluated against its foot's
// state and offered from the result register, which holds it while stalled.
// Throughput: one word per cycle unless the result side stalls; the per-foot state
// is read, updated and written back as the word advances, so same-foot words may
// follow back to back. Reset (rst_n, asynchronous, active low) clears all foot
// state, loads the default thresholds and empties both pipeline registers.
module force_contact_classifier_unit import fcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port.
    input  logic                      cfg_write_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // Input channel.
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [FOOT_W-1:0]         foot,
    input  logic signed [FORCE_W-1:0] force_req,
    input  logic                      force_valid,
    // Result channel.
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [FOOT_W-1:0]         result_foot,
    output logic                      in_contact,
    output logic                      touchdown
);

    cfg_t cfg;

    fcc_cfg_regs u_cfg_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Input register stage. It holds one word while the compute stage cannot
    // move, which happens only when the result register is full and stalled.
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [FOOT_W-1:0]         in_foot_reg;
    logic signed [FORCE_W-1:0] in_force_reg;
    logic                      in_fvalid_reg;

    logic in_accept;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_foot_reg   <= foot;
            in_force_reg  <= force_req;
            in_fvalid_reg <= force_valid;
        end
    end

    // Per-foot state. Only the addressed foot is read and, on advance, written;
    // a foot index beyond the configured number of feet touches nothing and
    // reports no contact.
    foot_state_t             state_reg [NUM_FEET];
    foot_state_t             state_next;
    logic [FEET_IDX_W-1:0]   foot_idx;
    logic                    foot_ok;
    logic                    eval_active;
    logic                    eval_touchdown;

    assign foot_idx = FEET_IDX_W'(in_foot_reg);
    assign foot_ok  = FOOT_CMP_W'(in_foot_reg) < FOOT_CMP_W'(NUM_FEET);

    fcc_eval u_eval
    (
        .cfg         (cfg),
        .cur         (state_reg[foot_idx]),
        .force_req   (in_force_reg),
        .force_valid (in_fvalid_reg),
        .nxt         (state_next),
        .now_active  (eval_active),
        .touchdown   (eval_touchdown)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{default: '0};
        else if (advance && foot_ok)
            state_reg[foot_idx] <= state_next;
    end

    // Result register. It takes a new word whenever the compute stage advances,
    // which includes the cycle in which the previous result is being taken.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [FOOT_W-1:0] out_foot_reg;
    logic              out_contact_reg;
    logic              out_touchdown_reg;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_foot_reg      <= in_foot_reg;
            out_contact_reg   <= foot_ok && eval_active;
            out_touchdown_reg <= foot_ok && eval_touchdown;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_foot = out_foot_reg;
    assign in_contact  = out_contact_reg;
    assign touchdown   = out_touchdown_reg;

endmodule

// ===== hdl/fcc_checker.sv =====
// Port-level checker for the force contact classifier, attached by bind.
// Depends only on the ports of force_contact_classifier_unit.
module fcc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_foot,
    input logic       in_contact,
    input logic       touchdown
);

    // A stalled result word stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_foot) &&
        $stable(in_contact) && $stable(touchdown))
        else $error("result word changed while stalled");

    // A touchdown always comes with contact reported in the same word.
    a_touchdown_contact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && touchdown |-> in_contact)
        else $error("touchdown reported without contact");

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the result side could move");

    // No result word is offered straight out of reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

    // A word taken into an empty pipeline goes on to the result register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid && !out_stall |=> ##1 out_valid)
        else $error("result word missing after an accepted input word");

endmodule

bind force_contact_classifier_unit fcc_checker u_fcc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_foot (result_foot),
    .in_contact  (in_contact),
    .touchdown   (touchdown)
);
